// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// No dependencies; used by tcw_front, tcw_back and the top level.
package tcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_CHAR    = 3'd0,
    K_NEWLINE = 3'd1,
    K_RETURN  = 3'd2,
    K_TAB     = 3'd3,
    K_CLEAR   = 3'd4,
    K_READ    = 3'd5,
    K_WRITE   = 3'd6,
    K_NONE    = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
    logic [7:0] color;
  } cmd_t;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam int         TAB_STOP   = 4;

endpackage

// ===== src/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcw_front.sv =====
// Front end: takes requests, range-checks the cell, forms the cell address
// and classifies the operation into a command. Uses tcw_pkg.
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int AW = $clog2(COLUMNS * ROWS)
) (
  input  logic          request_valid,
  output logic          request_stall,
  input  logic [1:0]    operation,
  input  logic [7:0]    character,
  input  logic [6:0]    cell_column,
  input  logic [4:0]    cell_row,
  input  logic [7:0]    cell_color,
  input  logic          q_full,
  input  logic          back_ready,
  output logic          push,
  output tcw_pkg::cmd_t cmd,
  output logic [AW-1:0] addr
);

  logic in_range;

  assign request_stall = q_full || !back_ready;
  assign push = request_valid && !request_stall;

  assign in_range = (9'(cell_column) < 9'(COLUMNS)) && (8'(cell_row) < 8'(ROWS));
  assign addr = AW'(32'(cell_row) * 32'(COLUMNS) + 32'(cell_column));

  always_comb begin
    cmd.char_code = character;
    cmd.color = cell_color;
    unique case (tcw_pkg::op_t'(operation))
      tcw_pkg::OP_PUT: begin
        unique case (character)
          tcw_pkg::CH_NEWLINE: cmd.kind = tcw_pkg::K_NEWLINE;
          tcw_pkg::CH_RETURN:  cmd.kind = tcw_pkg::K_RETURN;
          tcw_pkg::CH_TAB:     cmd.kind = tcw_pkg::K_TAB;
          default:             cmd.kind = tcw_pkg::K_CHAR;
        endcase
      end
      tcw_pkg::OP_CLEAR: cmd.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::OP_READ:  cmd.kind = in_range ? tcw_pkg::K_READ : tcw_pkg::K_NONE;
      tcw_pkg::OP_WRITE: cmd.kind = in_range ? tcw_pkg::K_WRITE : tcw_pkg::K_NONE;
      default:           cmd.kind = tcw_pkg::K_NONE;
    endcase
  end

endmodule

// ===== src/tcw_queue.sv =====
// Two-entry command queue between front and back end.
// No dependencies.
module tcw_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/tcw_back.sv =====
// Back end: executes commands on the character and attribute stores,
// tracks the cursor, scrolls, clears, and holds the result register.
// Uses tcw_pkg and tcw_ram.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int N = COLUMNS * ROWS,
  localparam int AW = $clog2(N)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tcw_pkg::cmd_t q_cmd,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  output logic          back_ready,
  input  logic          cfg_valid,
  input  logic [7:0]    cfg_data,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [6:0]    cursor_column,
  output logic [4:0]    cursor_row,
  output logic [10:0]   cursor_linear,
  output logic [7:0]    read_char,
  output logic [7:0]    read_color
);

  localparam int SW = $clog2(N + 1);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int CXW = (CW > 7) ? CW : 7;
  localparam int RXW = (RW > 5) ? RW : 5;
  localparam int LXW = (AW > 11) ? AW : 11;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_PUT    = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_BLANK  = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_READ   = 7'b1000000
  } state_t;

  state_t         state, state_next;
  logic [SW-1:0]  scan, scan_next;
  logic [CW-1:0]  cur_col, cur_col_next;
  logic [RW-1:0]  cur_row, cur_row_next;
  logic [AW-1:0]  cur_addr, cur_addr_next;
  logic [7:0]     put_char, put_char_next;
  logic [2:0]     tab_left, tab_left_next;
  logic [7:0]     blank_attr;
  logic           mv_valid;
  logic [AW-1:0]  mv_addr;

  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic           we_char, we_attr;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     wchar, wattr;
  logic [7:0]     rdata_char, rdata_attr;
  logic           resp, resp_read;
  logic           out_free, col_last, row_last;
  logic [CXW-1:0] col_ext;
  logic [RXW-1:0] row_ext;
  logic [LXW-1:0] lin_ext;

  assign out_free = !result_valid || !result_stall;
  assign q_pop = (state == S_IDLE) && q_valid && out_free;
  assign back_ready = (state != S_INIT);
  assign col_last = (cur_col == CW'(COLUMNS - 1));
  assign row_last = (cur_row == RW'(ROWS - 1));

  tcw_ram #(.WIDTH(8), .DEPTH(N)) u_char_ram (
    .clk(clk), .we(we_char), .waddr(ram_waddr), .wdata(wchar),
    .re(ram_re), .raddr(ram_raddr), .rdata(rdata_char)
  );

  tcw_ram #(.WIDTH(8), .DEPTH(N)) u_attr_ram (
    .clk(clk), .we(we_attr), .waddr(ram_waddr), .wdata(wattr),
    .re(ram_re), .raddr(ram_raddr), .rdata(rdata_attr)
  );

  always_comb begin
    state_next = state;
    scan_next = scan;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    cur_addr_next = cur_addr;
    put_char_next = put_char;
    tab_left_next = tab_left;
    ram_re = 1'b0;
    ram_raddr = q_addr;
    we_char = 1'b0;
    we_attr = 1'b0;
    ram_waddr = cur_addr;
    wchar = put_char;
    wattr = blank_attr;
    resp = 1'b0;
    resp_read = 1'b0;
    unique case (state)
      S_INIT: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        ram_waddr = scan[AW-1:0];
        wchar = tcw_pkg::BLANK_CHAR;
        wattr = tcw_pkg::RESET_ATTR;
        scan_next = scan + SW'(1);
        if (scan == SW'(N - 1)) begin
          scan_next = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.kind)
            tcw_pkg::K_CHAR: begin
              put_char_next = q_cmd.char_code;
              tab_left_next = 3'd1;
              state_next = S_PUT;
            end
            tcw_pkg::K_TAB: begin
              put_char_next = tcw_pkg::BLANK_CHAR;
              // column mod 4
              tab_left_next = 3'(tcw_pkg::TAB_STOP) - 3'(cur_col[1:0]);
              state_next = S_PUT;
            end
            tcw_pkg::K_NEWLINE: begin
              cur_col_next = '0;
              if (row_last) begin
                cur_addr_next = AW'(N - COLUMNS);
                tab_left_next = 3'd0;
                scan_next = SW'(COLUMNS);
                state_next = S_SCROLL;
              end else begin
                cur_row_next = cur_row + RW'(1);
                cur_addr_next = cur_addr - AW'(cur_col) + AW'(COLUMNS);
                resp = 1'b1;
              end
            end
            tcw_pkg::K_RETURN: begin
              cur_col_next = '0;
              cur_addr_next = cur_addr - AW'(cur_col);
              resp = 1'b1;
            end
            tcw_pkg::K_CLEAR: begin
              cur_col_next = '0;
              cur_row_next = '0;
              cur_addr_next = '0;
              scan_next = '0;
              state_next = S_CLEAR;
            end
            tcw_pkg::K_READ: begin
              ram_re = 1'b1;
              ram_raddr = q_addr;
              state_next = S_READ;
            end
            tcw_pkg::K_WRITE: begin
              we_char = 1'b1;
              we_attr = 1'b1;
              ram_waddr = q_addr;
              wchar = q_cmd.char_code;
              wattr = q_cmd.color;
              resp = 1'b1;
            end
            default: begin
              resp = 1'b1;
            end
          endcase
        end
      end
      S_PUT: begin
        we_char = 1'b1;
        ram_waddr = cur_addr;
        wchar = put_char;
        tab_left_next = tab_left - 3'd1;
        cur_addr_next = cur_addr + AW'(1);
        if (col_last && row_last) begin
          cur_col_next = '0;
          cur_addr_next = AW'(N - COLUMNS);
          scan_next = SW'(COLUMNS);
          state_next = S_SCROLL;
        end else begin
          if (col_last) begin
            cur_col_next = '0;
            cur_row_next = cur_row + RW'(1);
          end else begin
            cur_col_next = cur_col + CW'(1);
          end
          if (tab_left == 3'd1) begin
            resp = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_SCROLL: begin
        // read row r+1 while writing the cell read last cycle one row up
        ram_re = (scan != SW'(N));
        ram_raddr = scan[AW-1:0];
        we_char = mv_valid;
        we_attr = mv_valid;
        ram_waddr = mv_addr;
        wchar = rdata_char;
        wattr = rdata_attr;
        if (scan == SW'(N)) begin
          scan_next = SW'(N - COLUMNS);
          state_next = S_BLANK;
        end else begin
          scan_next = scan + SW'(1);
        end
      end
      S_BLANK: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        ram_waddr = scan[AW-1:0];
        wchar = tcw_pkg::BLANK_CHAR;
        wattr = blank_attr;
        scan_next = scan + SW'(1);
        if (scan == SW'(N - 1)) begin
          scan_next = '0;
          if (tab_left != 3'd0) begin
            state_next = S_PUT;
          end else begin
            resp = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        ram_waddr = scan[AW-1:0];
        wchar = tcw_pkg::BLANK_CHAR;
        wattr = blank_attr;
        scan_next = scan + SW'(1);
        if (scan == SW'(N - 1)) begin
          scan_next = '0;
          resp = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        resp = 1'b1;
        resp_read = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign col_ext = CXW'(cur_col_next);
  assign row_ext = RXW'(cur_row_next);
  assign lin_ext = LXW'(cur_addr_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      scan <= '0;
      cur_col <= '0;
      cur_row <= '0;
      cur_addr <= '0;
      tab_left <= 3'd0;
      mv_valid <= 1'b0;
      blank_attr <= tcw_pkg::RESET_ATTR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      scan <= scan_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      cur_addr <= cur_addr_next;
      tab_left <= tab_left_next;
      mv_valid <= (state == S_SCROLL) && ram_re;
      if (cfg_valid) begin
        blank_attr <= cfg_data;
      end
      if (resp) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    put_char <= put_char_next;
    mv_addr <= scan[AW-1:0] - AW'(COLUMNS);
    if (resp) begin
      cursor_column <= col_ext[6:0];
      cursor_row <= row_ext[4:0];
      cursor_linear <= lin_ext[10:0];
      read_char <= resp_read ? rdata_char : 8'd0;
      read_color <= resp_read ? rdata_attr : 8'd0;
    end
  end

endmodule

// ===== src/text_console_writer.sv =====
// Text console writer top level: front end, command queue, back end.
// Uses tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// Requests enter on request_valid/request_stall with operation, character,
// cell_column, cell_row and cell_color; a request is taken on a clock edge
// with request_valid high and request_stall low. Every request gives exactly
// one result on result_valid/result_stall: cursor after the operation, its
// linear form and, for a read, the cell's character and attribute.
// default_attribute is written over config_valid/config_ready (always ready)
// and applies to later clear and scroll operations.
// In the back end a printable character and a read each pass through a second
// state (put or read) after the idle state; write, carriage return, newline
// and ignored accesses are answered from the idle state unless they scroll;
// a tab writes one space per put step. The run time of clear and of each
// scroll is set by the single write port of the cell store, walked one cell
// per cycle. After reset the store is filled with blanks in attribute 7,
// with request_stall held high. A stalled result holds its value; the back
// end then stops and the two-entry queue fills before request_stall rises.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        request_valid,
  output logic        request_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  character,
  input  logic [6:0]  cell_column,
  input  logic [4:0]  cell_row,
  input  logic [7:0]  cell_color,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_linear,
  output logic [7:0]  read_char,
  output logic [7:0]  read_color,
  input  logic        config_valid,
  output logic        config_ready,
  input  logic [7:0]  default_attribute
);

  localparam int AW = $clog2(COLUMNS * ROWS);
  localparam int QW = $bits(tcw_pkg::cmd_t) + AW;

  logic          push, q_full, q_valid, q_pop, back_ready;
  tcw_pkg::cmd_t f_cmd, q_cmd;
  logic [AW-1:0] f_addr, q_addr;
  logic [QW-1:0] q_dout;

  assign config_ready = 1'b1;

  tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .request_valid(request_valid),
    .request_stall(request_stall),
    .operation(operation),
    .character(character),
    .cell_column(cell_column),
    .cell_row(cell_row),
    .cell_color(cell_color),
    .q_full(q_full),
    .back_ready(back_ready),
    .push(push),
    .cmd(f_cmd),
    .addr(f_addr)
  );

  tcw_queue #(.WIDTH(QW)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din({f_cmd, f_addr}),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .dout(q_dout)
  );

  assign q_cmd = q_dout[QW-1:AW];
  assign q_addr = q_dout[AW-1:0];

  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_cmd(q_cmd),
    .q_addr(q_addr),
    .q_pop(q_pop),
    .back_ready(back_ready),
    .cfg_valid(config_valid),
    .cfg_data(default_attribute),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cursor_column(cursor_column),
    .cursor_row(cursor_row),
    .cursor_linear(cursor_linear),
    .read_char(read_char),
    .read_color(read_color)
  );

endmodule

// ===== src/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
// Depends on text_console_writer.
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        request_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [6:0]  cursor_column,
  input logic [4:0]  cursor_row,
  input logic [10:0] cursor_linear,
  input logic [7:0]  read_char,
  input logic [7:0]  read_color
);

  localparam bit EXACT = (COLUMNS <= 128) && (ROWS <= 32);

  a_init_stall: assert property (@(posedge clk)
    rst |=> request_stall)
    else $error("request taken during store initialization");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid &&
      $stable({cursor_column, cursor_row, cursor_linear, read_char, read_color}))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (int'(cursor_column) < COLUMNS) && (int'(cursor_row) < ROWS))
    else $error("cursor out of screen");

  a_linear: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !EXACT ||
      (((int'(cursor_row) * COLUMNS + int'(cursor_column)) % 2048) == int'(cursor_linear)))
    else $error("linear cursor does not match row and column");

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (.*);
